### rtl/reaction_firing_engine_unit_assert.svh
// Assertion macros shared by the checker of the reaction firing engine.
`ifndef REACTION_FIRING_ENGINE_UNIT_ASSERT_SVH
`define REACTION_FIRING_ENGINE_UNIT_ASSERT_SVH

// Implication checked in the cycle after the antecedent.
`define RFE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("reaction firing engine: next-cycle check failed");

// Implication checked in the same cycle.
`define RFE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("reaction firing engine: same-cycle check failed");

`endif

### rtl/rfe_pkg.sv
// Shared types and codes of the reaction firing engine.
package rfe_pkg;

  localparam logic [2:0] REQ_WR_COEF  = 3'd0;
  localparam logic [2:0] REQ_WR_MOD   = 3'd1;
  localparam logic [2:0] REQ_WR_COUNT = 3'd2;
  localparam logic [2:0] REQ_RD_COUNT = 3'd3;
  localparam logic [2:0] REQ_TRY_FIRE = 3'd4;
  localparam logic [2:0] REQ_CHECK    = 3'd5;
  localparam logic [2:0] REQ_FORCE    = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  localparam logic REG_SPECIES   = 1'b0;
  localparam logic REG_REACTIONS = 1'b1;

  typedef enum logic [8:0] {
    S_CLEAR    = 9'b000000001,
    S_IDLE     = 9'b000000010,
    S_TBL_WR   = 9'b000000100,
    S_RD_CNT   = 9'b000001000,
    S_SCAN_RD  = 9'b000010000,
    S_SCAN_EV  = 9'b000100000,
    S_APPLY_RD = 9'b001000000,
    S_APPLY_WR = 9'b010000000,
    S_RESP     = 9'b100000000
  } state_t;

endpackage

### rtl/reaction_firing_engine_unit.sv
// Top level of the reaction firing engine: request sequencer over table and count memories.
//
// After reset the engine runs a clearing pass over the coefficient/modifier memory, one entry
// per cycle (2**(clog2(MAX_SPECIES)+clog2(MAX_REACTIONS)) entries, 16384 at the defaults);
// the count memory is cleared in the same pass, and in_ready stays low until it ends.
// Table writes are a read-modify-write of the shared table word; count writes are done when
// the word is accepted, count reads in a separate read state. Try fire and check scan the
// active species through the memory read port, with a read state and an evaluate state per
// species; try fire that succeeds and force apply add a second pass, with a read state and a
// write state per species, that writes the counts back. One word is in work at a time; a
// finished result sits in the output register while the next word is accepted.
module reaction_firing_engine_unit #(
  parameter int MAX_SPECIES   = 64,
  parameter int MAX_REACTIONS = 256,
  parameter int COUNT_WIDTH   = 32,
  parameter int COEF_WIDTH    = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_req_type,
  input  logic [5:0]         in_species_index,
  input  logic [7:0]         in_reaction_index,
  input  logic signed [7:0]  in_coefficient,
  input  logic [7:0]         in_modifier_need,
  input  logic [31:0]        in_count_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_enabled,
  output logic [31:0]        out_count_out,
  output logic [1:0]         out_status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int SP_W    = MAX_SPECIES > 1 ? $clog2(MAX_SPECIES) : 1;
  localparam int RX_W    = MAX_REACTIONS > 1 ? $clog2(MAX_REACTIONS) : 1;
  localparam int SCNT_W  = $clog2(MAX_SPECIES + 1);
  localparam int TBL_AW  = SP_W + RX_W;
  localparam int TBL_DEPTH = 1 << TBL_AW;
  localparam int CNT_DEPTH = 1 << SP_W;
  localparam int TW      = COEF_WIDTH + 8;
  localparam int SUM_W   = (COUNT_WIDTH > COEF_WIDTH ? COUNT_WIDTH : COEF_WIDTH) + 2;

  rfe_pkg::state_t state_r, state_nxt;

  logic [6:0]  species_in_use_r;
  logic [8:0]  reactions_in_use_r;

  logic [2:0]            req_r, req_nxt;
  logic [SP_W-1:0]       sp_r, sp_nxt;
  logic [RX_W-1:0]       rx_r, rx_nxt;
  logic [COEF_WIDTH-1:0] coef_r, coef_nxt;
  logic [7:0]            need_r, need_nxt;
  logic [SCNT_W-1:0]     s_r, s_nxt;
  logic                  ok_r, ok_nxt;
  logic                  sat_r, sat_nxt;
  logic [TBL_AW-1:0]     clr_r, clr_nxt;

  logic        res_en_r, res_en_nxt;
  logic [31:0] res_cnt_r, res_cnt_nxt;
  logic [1:0]  res_st_r, res_st_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_en_r, out_en_nxt;
  logic [31:0] out_cnt_r, out_cnt_nxt;
  logic [1:0]  out_st_r, out_st_nxt;

  logic                   tbl_we;
  logic [TBL_AW-1:0]      tbl_waddr, tbl_raddr;
  logic [TW-1:0]          tbl_wdata, tbl_rdata;
  logic                   cnt_we;
  logic [SP_W-1:0]        cnt_waddr, cnt_raddr;
  logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata;

  logic [15:0] ns, nr;
  logic        accept, cfg_wr, sp_ok, rx_ok, last;
  logic [SP_W-1:0]  in_sp;
  logic [RX_W-1:0]  in_rx;
  logic [15:0]      coef16;
  logic signed [SUM_W-1:0] sum;
  logic        sum_neg, sum_over, need_fail;
  logic [COUNT_WIDTH-1:0] sat_val;
  logic [63:0] cnt64, cval64;

  rfe_ram #(.WIDTH(TW), .DEPTH(TBL_DEPTH)) u_tbl (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .raddr(tbl_raddr), .rdata(tbl_rdata)
  );

  rfe_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(CNT_DEPTH)) u_cnt (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == rfe_pkg::REG_REACTIONS) ? {23'd0, reactions_in_use_r}
                                                       : {25'd0, species_in_use_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      species_in_use_r   <= 7'd64;
      reactions_in_use_r <= 9'd256;
    end else if (cfg_wr) begin
      if (paddr[2] == rfe_pkg::REG_REACTIONS) begin
        reactions_in_use_r <= pwdata[8:0];
      end else begin
        species_in_use_r <= pwdata[6:0];
      end
    end
  end

  assign ns = (16'(species_in_use_r) < 16'(MAX_SPECIES)) ? 16'(species_in_use_r)
                                                          : 16'(MAX_SPECIES);
  assign nr = (16'(reactions_in_use_r) < 16'(MAX_REACTIONS)) ? 16'(reactions_in_use_r)
                                                              : 16'(MAX_REACTIONS);

  assign in_ready = (state_r == rfe_pkg::S_IDLE);
  assign accept   = in_valid & in_ready;
  assign sp_ok    = 16'(in_species_index) < ns;
  assign rx_ok    = 16'(in_reaction_index) < nr;
  assign in_sp    = SP_W'(16'(in_species_index));
  assign in_rx    = RX_W'(16'(in_reaction_index));
  assign coef16   = 16'(in_coefficient);
  assign cval64   = 64'(in_count_value);
  assign cnt64    = 64'(cnt_rdata);
  assign last     = (16'(s_r) + 16'd1) >= ns;

  // Count plus signed coefficient, clamped to the count range.
  assign sum = $signed(SUM_W'(cnt_rdata))
             + $signed(SUM_W'($signed(tbl_rdata[COEF_WIDTH-1:0])));
  assign sum_neg   = sum[SUM_W-1];
  assign sum_over  = !sum_neg && (|sum[SUM_W-2:COUNT_WIDTH]);
  assign need_fail = 64'(cnt_rdata) < 64'(tbl_rdata[TW-1:COEF_WIDTH]);
  assign sat_val   = sum_neg ? '0 : (sum_over ? '1 : sum[COUNT_WIDTH-1:0]);

  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    sp_nxt      = sp_r;
    rx_nxt      = rx_r;
    coef_nxt    = coef_r;
    need_nxt    = need_r;
    s_nxt       = s_r;
    ok_nxt      = ok_r;
    sat_nxt     = sat_r;
    clr_nxt     = clr_r;
    res_en_nxt  = res_en_r;
    res_cnt_nxt = res_cnt_r;
    res_st_nxt  = res_st_r;
    tbl_we      = 1'b0;
    tbl_waddr   = {sp_r, rx_r};
    tbl_wdata   = '0;
    tbl_raddr   = {s_r[SP_W-1:0], rx_r};
    cnt_we      = 1'b0;
    cnt_waddr   = s_r[SP_W-1:0];
    cnt_wdata   = sat_val;
    cnt_raddr   = s_r[SP_W-1:0];

    unique case (state_r)
      rfe_pkg::S_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr_r;
        cnt_we    = 1'b1;
        cnt_waddr = clr_r[TBL_AW-1 -: SP_W];
        cnt_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (&clr_r) begin
          state_nxt = rfe_pkg::S_IDLE;
        end
      end
      rfe_pkg::S_IDLE: begin
        tbl_raddr = {in_sp, in_rx};
        cnt_raddr = in_sp;
        if (accept) begin
          req_nxt     = in_req_type;
          sp_nxt      = in_sp;
          rx_nxt      = in_rx;
          coef_nxt    = coef16[COEF_WIDTH-1:0];
          need_nxt    = in_modifier_need;
          s_nxt       = '0;
          ok_nxt      = 1'b1;
          sat_nxt     = 1'b0;
          res_en_nxt  = 1'b0;
          res_cnt_nxt = '0;
          res_st_nxt  = rfe_pkg::ST_OK;
          state_nxt   = rfe_pkg::S_RESP;
          case (in_req_type) inside
            rfe_pkg::REQ_WR_COEF, rfe_pkg::REQ_WR_MOD: begin
              if (sp_ok && rx_ok) begin
                state_nxt = rfe_pkg::S_TBL_WR;
              end else begin
                res_st_nxt = rfe_pkg::ST_RANGE;
              end
            end
            rfe_pkg::REQ_WR_COUNT: begin
              if (sp_ok) begin
                cnt_we    = 1'b1;
                cnt_waddr = in_sp;
                cnt_wdata = cval64[COUNT_WIDTH-1:0];
              end else begin
                res_st_nxt = rfe_pkg::ST_RANGE;
              end
            end
            rfe_pkg::REQ_RD_COUNT: begin
              if (sp_ok) begin
                state_nxt = rfe_pkg::S_RD_CNT;
              end else begin
                res_st_nxt = rfe_pkg::ST_RANGE;
              end
            end
            rfe_pkg::REQ_TRY_FIRE, rfe_pkg::REQ_CHECK, rfe_pkg::REQ_FORCE: begin
              if (!rx_ok) begin
                res_st_nxt = rfe_pkg::ST_RANGE;
              end else if (ns == 16'd0) begin
                // No active species: nothing to scan, the reaction counts as enabled (not for force apply).
                res_en_nxt = (in_req_type != rfe_pkg::REQ_FORCE);
              end else if (in_req_type == rfe_pkg::REQ_FORCE) begin
                state_nxt = rfe_pkg::S_APPLY_RD;
              end else begin
                state_nxt = rfe_pkg::S_SCAN_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      rfe_pkg::S_TBL_WR: begin
        tbl_we = 1'b1;
        if (req_r == rfe_pkg::REQ_WR_COEF) begin
          tbl_wdata = {tbl_rdata[TW-1:COEF_WIDTH], coef_r};
        end else begin
          tbl_wdata = {need_r, tbl_rdata[COEF_WIDTH-1:0]};
        end
        state_nxt = rfe_pkg::S_RESP;
      end
      rfe_pkg::S_RD_CNT: begin
        res_cnt_nxt = cnt64[31:0];
        state_nxt   = rfe_pkg::S_RESP;
      end
      rfe_pkg::S_SCAN_RD: begin
        state_nxt = rfe_pkg::S_SCAN_EV;
      end
      rfe_pkg::S_SCAN_EV: begin
        ok_nxt = ok_r && !sum_neg && !((req_r == rfe_pkg::REQ_TRY_FIRE) && need_fail);
        s_nxt  = s_r + 1'b1;
        state_nxt = rfe_pkg::S_SCAN_RD;
        if (last) begin
          s_nxt = '0;
          if (req_r == rfe_pkg::REQ_TRY_FIRE && ok_nxt) begin
            state_nxt = rfe_pkg::S_APPLY_RD;
          end else begin
            res_en_nxt = ok_nxt;
            state_nxt  = rfe_pkg::S_RESP;
          end
        end
      end
      rfe_pkg::S_APPLY_RD: begin
        state_nxt = rfe_pkg::S_APPLY_WR;
      end
      rfe_pkg::S_APPLY_WR: begin
        cnt_we  = 1'b1;
        sat_nxt = sat_r || sum_neg || sum_over;
        s_nxt   = s_r + 1'b1;
        state_nxt = rfe_pkg::S_APPLY_RD;
        if (last) begin
          state_nxt = rfe_pkg::S_RESP;
          if (req_r == rfe_pkg::REQ_TRY_FIRE) begin
            res_en_nxt = 1'b1;
          end else if (sat_nxt) begin
            res_st_nxt = rfe_pkg::ST_SAT;
          end
        end
      end
      rfe_pkg::S_RESP: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = rfe_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rfe_pkg::S_IDLE;
      end
    endcase
  end

  // Output register: loaded when the response state finds it free or being taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_en_nxt    = out_en_r;
    out_cnt_nxt   = out_cnt_r;
    out_st_nxt    = out_st_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == rfe_pkg::S_RESP && (!out_valid_r || out_ready)) begin
      out_valid_nxt = 1'b1;
      out_en_nxt    = res_en_r;
      out_cnt_nxt   = res_cnt_r;
      out_st_nxt    = res_st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rfe_pkg::S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    sp_r      <= sp_nxt;
    rx_r      <= rx_nxt;
    coef_r    <= coef_nxt;
    need_r    <= need_nxt;
    s_r       <= s_nxt;
    ok_r      <= ok_nxt;
    sat_r     <= sat_nxt;
    res_en_r  <= res_en_nxt;
    res_cnt_r <= res_cnt_nxt;
    res_st_r  <= res_st_nxt;
    out_en_r  <= out_en_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_enabled   = out_en_r;
  assign out_count_out = out_cnt_r;
  assign out_status    = out_st_r;

endmodule

### rtl/rfe_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/rfe_checker.sv
// Port-level checker of the reaction firing engine and its bind to the top level.
`include "reaction_firing_engine_unit_assert.svh"

module rfe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_enabled,
  input logic [31:0] out_count_out,
  input logic [1:0]  out_status
);

  logic cnt_zero;
  logic status_known;
  logic range_resp;

  assign cnt_zero     = (out_count_out == 32'd0);
  assign status_known = (out_status == rfe_pkg::ST_OK) || (out_status == rfe_pkg::ST_RANGE)
                      || (out_status == rfe_pkg::ST_SAT);
  assign range_resp   = out_valid && (out_status == rfe_pkg::ST_RANGE);

  `RFE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status))
  `RFE_ASSERT_SAME(a_status_code, out_valid, status_known)
  `RFE_ASSERT_SAME(a_range_quiet, range_resp, !out_enabled && cnt_zero)
  `RFE_ASSERT_SAME(a_enabled_clean, out_valid && out_enabled, out_status == rfe_pkg::ST_OK && cnt_zero)

endmodule

bind reaction_firing_engine_unit rfe_checker u_rfe_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_enabled(out_enabled),
  .out_count_out(out_count_out),
  .out_status(out_status)
);
